@@ sv/dda_line_point_generator_defines.svh @@
// Assertion macros shared by the checker of dda_line_point_generator.
// No dependencies; take it in by `include with the bare file name.
`ifndef DDA_LINE_POINT_GENERATOR_DEFINES_SVH
`define DDA_LINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DLPG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DLPG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dlpg_pkg.sv @@
// Package of the DDA line point generator: default widths and the control state type.
// No dependencies; used by dlpg_divider, dda_line_point_generator, dlpg_checker and the testbench.
package dlpg_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

endpackage

@@ sv/dlpg_divider.sv @@
// Bit-serial restoring divider: rounded (mag << FRAC_BITS + steps/2) / steps.
// Depends on dlpg_pkg for default parameter values.
module dlpg_divider
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_mag,
    input  logic [COORD_BITS-1:0] i_steps,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_quot
);

    localparam int NUM_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [COORD_BITS-1:0] r_div;
    logic [COORD_BITS-1:0] r_rem;
    logic [FRAC_BITS:0]    r_num;   // numerator bits going out, quotient bits coming in

    logic [NUM_BITS-1:0]   w_num;
    logic [COORD_BITS:0]   w_sh;
    logic [COORD_BITS:0]   w_diff;
    logic                  w_ge;

    // The quotient never exceeds 2^FRAC_BITS, so the numerator bits from
    // FRAC_BITS+1 up already sit below the divisor and seed the remainder.
    assign w_num  = {1'b0, i_mag, {FRAC_BITS{1'b0}}} + NUM_BITS'(i_steps >> 1);
    assign w_sh   = {r_rem, r_num[FRAC_BITS]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_steps;
            r_rem <= w_num[NUM_BITS-1:FRAC_BITS+1];
            r_num <= w_num[FRAC_BITS:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COORD_BITS-1:0] : w_sh[COORD_BITS-1:0];
            r_num <= {r_num[FRAC_BITS-1:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ sv/dda_line_point_generator.sv @@
// Top level of the DDA line point generator: request decode, accumulators, result register.
// Depends on dlpg_pkg and dlpg_divider.
//
// A load request (req_type 0) carries two endpoints. Its result, the start point,
// is presented in the cycle after the request is accepted. For a segment of nonzero
// length the block then takes no request while the bit-serial dividers form the x
// and y increments, one quotient bit per cycle for each axis; a zero-length segment
// needs no division and adds no stall. A next request (req_type 1) is one add per
// axis on the position accumulators, and while no division runs a new request is
// taken in every cycle in which the result register is empty or its result is
// being taken. Points are rounded half up, the endpoint is flagged last_point, a
// zero-length segment gives one point flagged last, and a next request with no
// active segment returns no_point with zero coordinates. A load drops any segment
// still in progress.
module dda_line_point_generator
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_req_type,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_point_x,
    output logic [COORD_BITS-1:0] o_point_y,
    output logic                  o_last_point,
    output logic                  o_no_point
);

    localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 2;
    localparam int INC_BITS = FRAC_BITS + 2;

    // Control.
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_load;
    logic   w_next;
    logic   w_div_start;
    logic   w_div_done;
    logic   w_div_done_x;
    logic   w_div_done_y;

    // Segment setup from the request fields.
    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS:0]        w_ax_full;
    logic [COORD_BITS:0]        w_ay_full;
    logic [COORD_BITS-1:0]      w_ax;
    logic [COORD_BITS-1:0]      w_ay;
    logic [COORD_BITS-1:0]      w_steps;
    logic [FRAC_BITS:0]         w_quot_x;
    logic [FRAC_BITS:0]         w_quot_y;

    // Segment state. The accumulators hold the position plus one half LSB,
    // so the rounded coordinate is a plain bit slice.
    logic [ACC_BITS-1:0]   r_acc_x;
    logic [ACC_BITS-1:0]   r_acc_y;
    logic [INC_BITS-1:0]   r_inc_x;
    logic [INC_BITS-1:0]   r_inc_y;
    logic [COORD_BITS-1:0] r_steps_left;
    logic                  r_active;
    logic                  r_neg_x;
    logic                  r_neg_y;
    logic [ACC_BITS-1:0]   w_sum_x;
    logic [ACC_BITS-1:0]   w_sum_y;

    // Result register.
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_point_x;
    logic [COORD_BITS-1:0] r_point_y;
    logic                  r_last_point;
    logic                  r_no_point;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = w_accept && !i_req_type;
    assign w_next   = w_accept && i_req_type;

    // Deltas and the step count: the larger of |dx| and |dy|.
    assign w_dx      = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
    assign w_dy      = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
    assign w_ax_full = w_dx[COORD_BITS] ? (-w_dx) : w_dx;
    assign w_ay_full = w_dy[COORD_BITS] ? (-w_dy) : w_dy;
    assign w_ax      = w_ax_full[COORD_BITS-1:0];
    assign w_ay      = w_ay_full[COORD_BITS-1:0];
    assign w_steps   = (w_ax > w_ay) ? w_ax : w_ay;

    // Advance both accumulators by the sign-extended increments.
    assign w_sum_x = r_acc_x + {{(ACC_BITS-INC_BITS){r_inc_x[INC_BITS-1]}}, r_inc_x};
    assign w_sum_y = r_acc_y + {{(ACC_BITS-INC_BITS){r_inc_y[INC_BITS-1]}}, r_inc_y};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_load && (w_steps != '0)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: take a request only when idle and the result slot frees up.
    always_comb begin
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = !r_out_valid || i_out_ready;
                w_div_start = w_load && (w_steps != '0);
            end
            ST_DIV: begin
                o_in_ready  = 1'b0;
                w_div_start = 1'b0;
            end
            default: begin
                o_in_ready  = 1'b0;
                w_div_start = 1'b0;
            end
        endcase
    end

    dlpg_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (w_ax),
        .i_steps (w_steps),
        .o_done  (w_div_done_x),
        .o_quot  (w_quot_x)
    );

    // Runs in lockstep with the x divider.
    dlpg_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_mag   (w_ay),
        .i_steps (w_steps),
        .o_done  (w_div_done_y),
        .o_quot  (w_quot_y)
    );

    // Hold the setup until both increments are ready.
    assign w_div_done = w_div_done_x && w_div_done_y;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_active <= (w_steps != '0);
            end else if (w_next && r_active && (r_steps_left == COORD_BITS'(1))) begin
                r_active <= 1'b0;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Segment datapath.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_acc_x      <= {2'b00, i_x_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
            r_acc_y      <= {2'b00, i_y_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
            r_steps_left <= w_steps;
            r_neg_x      <= w_dx[COORD_BITS];
            r_neg_y      <= w_dy[COORD_BITS];
            r_inc_x      <= '0;
            r_inc_y      <= '0;
        end else if (w_next && r_active) begin
            r_acc_x      <= w_sum_x;
            r_acc_y      <= w_sum_y;
            r_steps_left <= r_steps_left - 1'b1;
        end else if (w_div_done) begin
            // Apply the delta's sign to the rounded magnitude.
            r_inc_x <= r_neg_x ? (-{1'b0, w_quot_x}) : {1'b0, w_quot_x};
            r_inc_y <= r_neg_y ? (-{1'b0, w_quot_y}) : {1'b0, w_quot_y};
        end
    end

    // Result payload: load gives the start point, next the advanced point or no_point.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_point_x    <= i_x_start;
            r_point_y    <= i_y_start;
            r_last_point <= (w_steps == '0);
            r_no_point   <= 1'b0;
        end else if (w_next && r_active) begin
            r_point_x    <= w_sum_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            r_point_y    <= w_sum_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            r_last_point <= (r_steps_left == COORD_BITS'(1));
            r_no_point   <= 1'b0;
        end else if (w_next) begin
            r_point_x    <= '0;
            r_point_y    <= '0;
            r_last_point <= 1'b0;
            r_no_point   <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_point_x    = r_point_x;
    assign o_point_y    = r_point_y;
    assign o_last_point = r_last_point;
    assign o_no_point   = r_no_point;

endmodule

@@ sv/dlpg_checker.sv @@
// Port-level checker of dda_line_point_generator, bound to every instance of it.
// Depends on dlpg_pkg and on dda_line_point_generator_defines.svh for the macros.
`include "dda_line_point_generator_defines.svh"

module dlpg_checker
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_req_type,
    input logic [COORD_BITS-1:0] i_x_start,
    input logic [COORD_BITS-1:0] i_y_start,
    input logic [COORD_BITS-1:0] i_x_end,
    input logic [COORD_BITS-1:0] i_y_end,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] o_point_x,
    input logic [COORD_BITS-1:0] o_point_y,
    input logic                  o_last_point,
    input logic                  o_no_point
);

    logic w_load_acc;
    logic w_zero_len;

    assign w_load_acc = i_in_valid && o_in_ready && !i_req_type;
    assign w_zero_len = (i_x_start == i_x_end) && (i_y_start == i_y_end);

    // A load request shows its start point in the next cycle.
    `DLPG_ASSERT_NXT(a_load_start_point, i_clk, i_rst_n, w_load_acc,
        o_out_valid && !o_no_point && (o_point_x == $past(i_x_start))
            && (o_point_y == $past(i_y_start)),
        "load request did not return its start point")

    // A zero-length segment ends at its only point.
    `DLPG_ASSERT_NXT(a_zero_len_last, i_clk, i_rst_n, w_load_acc && w_zero_len,
        o_out_valid && o_last_point, "zero-length segment point not flagged last")

    // An empty result carries zero coordinates and no last flag.
    `DLPG_ASSERT_IMP(a_no_point_clean, i_clk, i_rst_n, o_out_valid && o_no_point,
        (o_point_x == '0) && (o_point_y == '0) && !o_last_point,
        "no_point result carries coordinates")

    // A stalled result holds.
    `DLPG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_last_point) && $stable(o_no_point),
        "stalled result changed")

endmodule

bind dda_line_point_generator dlpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_dlpg_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for dda_line_point_generator: directed and random load/next requests, each
// point checked against a DDA predictor kept in the bench. Depends on dlpg_pkg and the RTL.
module testbench;
    import dlpg_pkg::*;

    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 2;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_NEXT   = 1'b1;
    localparam logic [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1) << (FRAC_BITS - 1);
    localparam int REQUEST_COUNT = 1350;
    localparam int PHASE_LEN     = 150;   // requests per idling phase
    localparam int HOLD_AFTER    = 600;   // requests taken before the long output hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 2 * (FRAC_BITS + 2) + 10;
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ACC_BITS-1:0]   t_acc;

    typedef struct {
        logic   req_type;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_line_request;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last_point;
        logic   no_point;
    } t_line_point;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Request channel
    logic   in_valid = 1'b0;
    logic   in_ready;
    logic   req_type = REQ_LOAD;
    t_coord x_start  = '0;
    t_coord y_start  = '0;
    t_coord x_end    = '0;
    t_coord y_end    = '0;

    // Point channel
    logic   out_valid;
    logic   out_ready = 1'b0;
    t_coord point_x;
    t_coord point_y;
    logic   last_point;
    logic   no_point;

    dda_line_point_generator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_x_start    (x_start),
        .i_y_start    (y_start),
        .i_x_end      (x_end),
        .i_y_end      (y_end),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_point_x    (point_x),
        .o_point_y    (point_y),
        .o_last_point (last_point),
        .o_no_point   (no_point)
    );

    t_line_request pending_requests[$];
    t_line_point   expected_points[$];
    t_line_request offered;

    // Shared counters move by nonblocking assignment, but mismatches by blocking increment
    int requests_taken = 0;
    int points_taken   = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int mismatches     = 0;

    // Line state as the block should hold it
    t_acc   line_x_acc      = '0;
    t_acc   line_y_acc      = '0;
    longint step_x          = 0;
    longint step_y          = 0;
    int     steps_remaining = 0;
    bit     line_active     = 1'b0;

    // Tallies for the closing summary
    int loads_taken    = 0;
    int nexts_taken    = 0;
    int idle_nexts     = 0;
    int segment_ends   = 0;

    // Idle percentage of one side for the phase the run is in
    function automatic int idle_pct(int taken, bit receiver);
        case ((taken / PHASE_LEN) % 5)
            1: return receiver ? 0 : 52;
            2: return receiver ? 52 : 0;
            3: return 20;
            default: return 0;
        endcase
    endfunction

    // Per-step increment: magnitude rounded to nearest, ties away from zero, then signed
    function automatic longint step_size(int d, int span);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = ((mag << FRAC_BITS) + span / 2) / span;
        return (d < 0) ? -q : q;
    endfunction

    // Round half up and keep the coordinate bits
    function automatic t_coord rounded(t_acc acc);
        t_acc sum;
        sum = acc + HALF_LSB;
        return sum[FRAC_BITS +: COORD_BITS];
    endfunction

    // Advance the line state by one request and return the point it yields
    function automatic t_line_point next_line_point(t_line_request r);
        t_line_point p;
        int dx;
        int dy;
        int span;
        p = '{x: '0, y: '0, last_point: 1'b0, no_point: 1'b0};
        if (r.req_type == REQ_LOAD) begin
            loads_taken++;
            dx = int'(r.x_end) - int'(r.x_start);
            dy = int'(r.y_end) - int'(r.y_start);
            span = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > span)
                span = (dy < 0) ? -dy : dy;
            line_x_acc = t_acc'(r.x_start) << FRAC_BITS;
            line_y_acc = t_acc'(r.y_start) << FRAC_BITS;
            steps_remaining = span;
            line_active = (span != 0);
            step_x = (span != 0) ? step_size(dx, span) : 0;
            step_y = (span != 0) ? step_size(dy, span) : 0;
            p.last_point = (span == 0);
        end else begin
            nexts_taken++;
            if (line_active) begin
                line_x_acc = line_x_acc + t_acc'(step_x);
                line_y_acc = line_y_acc + t_acc'(step_y);
                steps_remaining--;
                if (steps_remaining == 0) begin
                    line_active = 1'b0;
                    p.last_point = 1'b1;
                end
            end else begin
                p.no_point = 1'b1;
                idle_nexts++;
            end
        end
        if (!p.no_point) begin
            p.x = rounded(line_x_acc);
            p.y = rounded(line_y_acc);
        end
        if (p.last_point)
            segment_ends++;
        return p;
    endfunction

    function automatic void add_request(logic kind, int xs, int ys, int xe, int ye);
        pending_requests.push_back('{req_type: kind, x_start: t_coord'(xs),
                                     y_start: t_coord'(ys), x_end: t_coord'(xe),
                                     y_end: t_coord'(ye)});
    endfunction

    // Next request with junk in the endpoint fields, which the block must ignore
    function automatic void add_next();
        add_request(REQ_NEXT, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Coordinate within a short reach of c, clipped to the field range
    function automatic int nearby(int c);
        int v;
        v = c + int'($urandom_range(40)) - 20;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    // Driver: offer the next pending request, hold it until taken, predict on acceptance
    always @(posedge i_clk) begin
        logic take;
        take = in_valid && in_ready;
        if (take) begin
            expected_points.push_back(next_line_point(offered));
            requests_taken <= requests_taken + 1;
        end
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || take) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= idle_pct(requests_taken, 1'b0)) begin
                offered = pending_requests.pop_front();
                in_valid <= 1'b1;
                req_type <= offered.req_type;
                x_start  <= offered.x_start;
                y_start  <= offered.y_start;
                x_end    <= offered.x_end;
                y_end    <= offered.y_end;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each point taken against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        t_line_point want;
        if (out_valid && out_ready) begin
            points_taken <= points_taken + 1;
            if (expected_points.size() == 0) begin
                $error("point (%0d,%0d) arrived with no request waiting", point_x, point_y);
                mismatches++;
            end else begin
                want = expected_points.pop_front();
                if (point_x !== want.x) begin
                    $error("point_x: expected %0d, got %0d", want.x, point_x);
                    mismatches++;
                end
                if (point_y !== want.y) begin
                    $error("point_y: expected %0d, got %0d", want.y, point_y);
                    mismatches++;
                end
                if (last_point !== want.last_point) begin
                    $error("last_point: expected %0b, got %0b", want.last_point, last_point);
                    mismatches++;
                end
                if (no_point !== want.no_point) begin
                    $error("no_point: expected %0b, got %0b", want.no_point, no_point);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) &&
                         ($urandom_range(99) >= idle_pct(requests_taken, 1'b1));
    end

    // Long output hold-off, once: the sender keeps offering so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int pick;
        int xs;
        int ys;
        int xe;
        int ye;
        int span;
        int walk;

        // Directed: idle next, zero-length segments at both corners, short walks,
        // a load that drops a live segment, full-scale diagonal, unit vertical step
        add_request(REQ_NEXT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        add_request(REQ_LOAD, 0, 0, 0, 0);
        add_request(REQ_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        add_request(REQ_NEXT, 0, 0, 0, 0);
        add_request(REQ_LOAD, 0, 0, 3, 1);
        repeat (3) add_next();
        add_request(REQ_NEXT, COORD_MAX, 0, COORD_MAX, 0);
        add_request(REQ_LOAD, COORD_MAX, COORD_MAX, 0, COORD_MAX - 5);
        repeat (2) add_next();
        add_request(REQ_LOAD, 2, 7, 5, 3);
        repeat (4) add_next();
        add_request(REQ_LOAD, 0, COORD_MAX, COORD_MAX, 0);
        repeat (2) add_next();
        add_request(REQ_LOAD, 512, 0, 512, 1);
        add_next();

        // Random: mostly complete segments, some cut short by a reload, some stray nexts
        while (pending_requests.size() < REQUEST_COUNT) begin
            pick = $urandom_range(99);
            xs = $urandom_range(COORD_MAX);
            ys = $urandom_range(COORD_MAX);
            if ($urandom_range(14) == 0) begin
                xe = $urandom_range(COORD_MAX);
                ye = $urandom_range(COORD_MAX);
            end else begin
                xe = nearby(xs);
                ye = nearby(ys);
            end
            if (pick < 6) begin
                add_next();
            end else begin
                add_request(REQ_LOAD, xs, ys, xe, ye);
                span = (xe > xs) ? xe - xs : xs - xe;
                if (((ye > ys) ? ye - ys : ys - ye) > span)
                    span = (ye > ys) ? ye - ys : ys - ye;
                walk = span;
                if (pick < 14 && span > 0)
                    walk = $urandom_range(span - 1);
                if (walk > 300)
                    walk = $urandom_range(300);
                repeat (walk) add_next();
                if ($urandom_range(9) == 0)
                    add_next();
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (pending_requests.size() != 0 || in_valid);
        do @(negedge i_clk); while (expected_points.size() != 0);
        // Let a trailing division finish; any stray point is caught by the monitor
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d loads and %0d next requests (%0d with no segment), %0d ends",
                 loads_taken, nexts_taken, idle_nexts, segment_ends);
        $display("checked %0d points in %0d cycles, %0d mismatches",
                 points_taken, cycle_count, mismatches);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
